// File: hdl/spbf_pkg.sv
// Package for the segment-preserving byte fifo.
// Operation and status codes, store sizes and register indices. No dependencies.
package spbf_pkg;
   localparam int STORE_BYTES   = 16384;
   localparam int SEGMENT_MAX   = 1024;
   localparam int SEGMENT_SLOTS = 1024;
   localparam int BP_W = $clog2(STORE_BYTES);
   localparam int SP_W = $clog2(SEGMENT_SLOTS);
   localparam int SC_W = $clog2(SEGMENT_SLOTS + 1);
   localparam int SL_W = $clog2(SEGMENT_MAX + 1);

   typedef enum logic [2:0] {
      OP_WRITE_BEGIN = 3'd0,
      OP_WRITE_BYTE  = 3'd1,
      OP_READ_BEGIN  = 3'd2,
      OP_READ_BYTE   = 3'd3,
      OP_TRIM        = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_NO_DATA   = 3'd3,
      ST_NOT_OPEN  = 3'd4
   } status_type;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_SEG_LIMIT = 2'd1;
   localparam logic [1:0] CSR_PACKET = 2'd2;
   localparam logic [1:0] CSR_TRIM = 2'd3;
endpackage

// File: hdl/stream_packet_byte_fifo.sv
// Top level of the segment-preserving byte fifo.
// Uses spbf_pkg. Holds the byte ring and segment length ring memories.
//
// Usage: req_ carries one operation per transfer, tuser = operation, tdata =
// {length, data_in} from bit 0 up. rsp_ returns one result per request,
// tuser = status, tlast = last byte of a read or write transfer, tdata =
// {data_out, free_bytes} from bit 0 up. csr_ writes registers 0..3
// (capacity, segment limit, packet mode, trim enable); the user must write
// them only while idle, as the block itself does no check. The accepting edge
// captures the request and issues the memory reads, state S_EXEC commits,
// and state S_OUT loads the output register and raises rsp_tvalid. A new
// request is taken only in S_IDLE, so each request is done before the next.
// A segment drop (end of packet-mode read, end of head segment, trim) adds,
// per dropped segment, S_DROP to retire the head and, unless no segment is
// left, S_DROPRD for the next head length to come back from segment memory.
// A result waits in the output register while rsp_tready is low, and
// req_tready stays low meanwhile; the next request is taken when that
// register is empty or being emptied. Reset clears state, pointers and counts
// and presets the CSRs; the memories and data registers are not cleared.
module stream_packet_byte_fifo
   import spbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // operation
   input  logic [23:0] req_tdata,   // length[14:0], data_in[22:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   output logic [23:0] rsp_tdata,   // data_out[7:0], free_bytes[23:8]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DROPRD, S_DROP, S_OUT} state_type;

   logic [7:0]      bmem [STORE_BYTES];
   logic [SL_W-1:0] smem [SEGMENT_SLOTS];

   state_type       state_ff;
   logic [2:0]      op_ff;
   logic [14:0]     len_ff;
   logic [7:0]      din_ff;
   logic [BP_W-1:0] rp_ff, wp_ff;
   logic [SP_W-1:0] hp_ff, tp_ff;
   logic [SC_W-1:0] cnt_ff;
   logic [14:0]     stored_ff, rrem_ff;
   logic [SL_W-1:0] hrem_ff, wrem_ff;
   logic [14:0]     cap_ff;
   logic [SL_W-1:0] lim_ff;
   logic            pkt_ff, trim_ff, trimming_ff;
   logic [7:0]      brd_ff;
   logic [SL_W-1:0] srd_ff;
   logic            rv_ff;
   logic [2:0]      st_ff;
   logic [7:0]      dout_ff;
   logic            last_ff;
   logic [15:0]     free_ff;

   logic signed [16:0] fr;
   logic [SL_W-1:0]    done_w;
   logic [14:0]        hr15;
   logic [SP_W-1:0]    hp_next;
   logic               wb_ok;
   assign fr = $signed({2'b0, cap_ff}) - $signed({2'b0, stored_ff});
   assign done_w = (srd_ff >= wrem_ff) ? srd_ff - wrem_ff : '0;
   assign hr15 = 15'(hrem_ff);
   assign hp_next = hp_ff + 1'b1;
   assign wb_ok = (len_ff <= 15'(lim_ff)) && (fr > 0) && !($signed({2'b0, len_ff}) > fr)
                  && len_ff != '0 && cnt_ff < SC_W'(SEGMENT_SLOTS);

   assign req_tready = (state_ff == S_IDLE) && (!rv_ff || rsp_tready);
   assign rsp_tvalid = rv_ff;
   assign rsp_tuser = st_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {free_ff, dout_ff};

   always_ff @(posedge clock) begin
      brd_ff <= bmem[rp_ff];
      if (state_ff == S_DROP) srd_ff <= smem[hp_next];
      else srd_ff <= smem[tp_ff];
      if (state_ff == S_EXEC && op_ff == OP_WRITE_BYTE && wrem_ff != '0)
         bmem[wp_ff] <= din_ff;
      if (state_ff == S_EXEC && op_ff == OP_WRITE_BEGIN && wb_ok)
         smem[tp_ff] <= SL_W'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0;
         rp_ff <= '0; wp_ff <= '0; hp_ff <= '0; tp_ff <= '0; cnt_ff <= '0;
         stored_ff <= '0; hrem_ff <= '0; wrem_ff <= '0; rrem_ff <= '0;
         cap_ff <= 15'd8192; lim_ff <= SL_W'(512); pkt_ff <= 1'b0; trim_ff <= 1'b0;
         trimming_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY:
                  if (csr_wdata != '0 && 32'(csr_wdata) <= STORE_BYTES) cap_ff <= csr_wdata;
               CSR_SEG_LIMIT:
                  if (32'(csr_wdata[10:0]) <= SEGMENT_MAX) lim_ff <= SL_W'(csr_wdata[10:0]);
               CSR_PACKET: pkt_ff <= csr_wdata[0];
               CSR_TRIM: trim_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff <= req_tuser; len_ff <= req_tdata[14:0];
               din_ff <= req_tdata[22:15];
               st_ff <= ST_OK; dout_ff <= '0; last_ff <= 1'b0;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_OUT;
               case (op_ff)
                  OP_WRITE_BEGIN: begin
                     if (wrem_ff != '0) wp_ff <= wp_ff - BP_W'(done_w);
                     wrem_ff <= wb_ok ? SL_W'(len_ff) : '0;
                     if (15'(len_ff) > 15'(lim_ff)) st_ff <= ST_TOO_LONG;
                     else if (fr <= 0 || $signed({2'b0, len_ff}) > fr) st_ff <= ST_NO_SPACE;
                     else if (len_ff == '0) st_ff <= ST_OK;
                     else if (cnt_ff >= SC_W'(SEGMENT_SLOTS)) st_ff <= ST_NO_SPACE;
                  end
                  OP_WRITE_BYTE: begin
                     if (wrem_ff == '0) st_ff <= ST_NOT_OPEN;
                     else begin
                        wp_ff <= wp_ff + 1'b1;
                        wrem_ff <= wrem_ff - 1'b1;
                        if (wrem_ff == SL_W'(1)) begin
                           if (cnt_ff == '0) hrem_ff <= srd_ff;
                           tp_ff <= tp_ff + 1'b1;
                           cnt_ff <= cnt_ff + 1'b1;
                           stored_ff <= stored_ff + 15'(srd_ff);
                           last_ff <= 1'b1;
                        end
                     end
                  end
                  OP_READ_BEGIN: begin
                     if (len_ff > stored_ff) st_ff <= ST_NO_DATA;
                     else rrem_ff <= len_ff;
                  end
                  OP_READ_BYTE: begin
                     if (rrem_ff == '0) st_ff <= ST_NOT_OPEN;
                     else if (cnt_ff == '0 || hrem_ff == '0 || stored_ff == '0)
                        st_ff <= ST_NO_DATA;
                     else begin
                        dout_ff <= brd_ff;
                        rp_ff <= rp_ff + 1'b1;
                        stored_ff <= stored_ff - 1'b1;
                        hrem_ff <= hrem_ff - 1'b1;
                        rrem_ff <= rrem_ff - 1'b1;
                        if (rrem_ff == 15'd1) last_ff <= 1'b1;
                        if (hrem_ff == SL_W'(1) || (rrem_ff == 15'd1 && pkt_ff)) begin
                           trimming_ff <= 1'b0;
                           state_ff <= S_DROP;
                        end
                     end
                  end
                  OP_TRIM: if (trim_ff && stored_ff > cap_ff && cnt_ff != '0) begin
                     trimming_ff <= 1'b1;
                     state_ff <= S_DROP;
                  end
                  default: ;
               endcase
            end
            S_DROP: begin
               // remove head segment; next head length is read meanwhile
               rp_ff <= rp_ff + BP_W'(hrem_ff);
               stored_ff <= (hr15 <= stored_ff) ? stored_ff - hr15 : '0;
               hp_ff <= hp_next;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == SC_W'(1)) begin
                  hrem_ff <= '0;
                  state_ff <= S_OUT;
               end else state_ff <= S_DROPRD;
            end
            S_DROPRD: begin
               hrem_ff <= srd_ff;
               if (trimming_ff && stored_ff > cap_ff) state_ff <= S_DROP;
               else state_ff <= S_OUT;
            end
            S_OUT: begin
               free_ff <= fr[15:0];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rv_ff && !rsp_tready |=> rv_ff)
      else $error("result lost under stall");
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_EXEC) else $error("accept not executed");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= SC_W'(SEGMENT_SLOTS))
      else $error("segment count overflow");
endmodule

// File: tb/stream_packet_byte_fifo_tb.sv
// Testbench for stream_packet_byte_fifo: directed and random operation streams,
// checked against an in-bench predictor of the segment fifo. Depends on spbf_pkg.
module stream_packet_byte_fifo_tb;
   import spbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  data_out;
      logic        last;
      logic [15:0] free_bytes;
   } fifo_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   stream_packet_byte_fifo dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  ring_bytes [STORE_BYTES];
   int unsigned seg_len [SEGMENT_SLOTS];
   int unsigned rd_ptr, wr_ptr, seg_head, seg_tail, seg_cnt, stored;
   int unsigned head_left, wr_left, rd_left, cap, seg_lim;
   bit          pkt_mode, trim_en;

   fifo_result_type pending_results [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_cycles = 0;

   function automatic int free_now();
      return int'(cap) - int'(stored);
   endfunction

   task automatic drop_head_segment();
      if (seg_cnt == 0) return;
      rd_ptr = (rd_ptr + head_left) % STORE_BYTES;
      stored -= (head_left <= stored) ? head_left : stored;
      seg_head = (seg_head + 1) % SEGMENT_SLOTS;
      seg_cnt--;
      head_left = (seg_cnt > 0) ? seg_len[seg_head] : 0;
   endtask

   task automatic predict_fifo(input logic [2:0] op, input int unsigned len,
                               input logic [7:0] din);
      fifo_result_type r;
      int unsigned  done;
      r = '{ST_OK, 8'd0, 1'b0, 16'd0};
      case (op)
         OP_WRITE_BEGIN: begin
            if (wr_left > 0) begin
               done = (seg_len[seg_tail] >= wr_left) ? seg_len[seg_tail] - wr_left : 0;
               wr_ptr = (wr_ptr + STORE_BYTES - (done % STORE_BYTES)) % STORE_BYTES;
               wr_left = 0;
            end
            if (len > seg_lim) r.status = ST_TOO_LONG;
            else if (free_now() <= 0 || int'(len) > free_now()) r.status = ST_NO_SPACE;
            else if (len == 0) r.status = ST_OK;
            else if (seg_cnt >= SEGMENT_SLOTS) r.status = ST_NO_SPACE;
            else begin
               seg_len[seg_tail] = len;
               wr_left = len;
            end
         end
         OP_WRITE_BYTE: begin
            if (wr_left == 0) r.status = ST_NOT_OPEN;
            else begin
               ring_bytes[wr_ptr] = din;
               wr_ptr = (wr_ptr + 1) % STORE_BYTES;
               wr_left--;
               if (wr_left == 0) begin
                  if (seg_cnt == 0) head_left = seg_len[seg_tail];
                  stored += seg_len[seg_tail];
                  seg_tail = (seg_tail + 1) % SEGMENT_SLOTS;
                  seg_cnt++;
                  r.last = 1'b1;
               end
            end
         end
         OP_READ_BEGIN: begin
            if (len > stored) r.status = ST_NO_DATA;
            else rd_left = len;
         end
         OP_READ_BYTE: begin
            if (rd_left == 0) r.status = ST_NOT_OPEN;
            else if (seg_cnt == 0 || head_left == 0 || stored == 0) r.status = ST_NO_DATA;
            else begin
               r.data_out = ring_bytes[rd_ptr];
               rd_ptr = (rd_ptr + 1) % STORE_BYTES;
               stored--;
               head_left--;
               rd_left--;
               if (head_left == 0) drop_head_segment();
               else if (rd_left == 0 && pkt_mode) drop_head_segment();
               if (rd_left == 0) r.last = 1'b1;
            end
         end
         OP_TRIM: begin
            if (trim_en)
               while (stored > cap && seg_cnt > 0) drop_head_segment();
         end
         default: ;
      endcase
      r.free_bytes = 16'(free_now());
      pending_results.push_back(r);
   endtask

   task automatic send_op(input logic [2:0] op, input int unsigned len,
                          input logic [7:0] din = 8'd0);
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) req_tvalid = 1'b0;
         else break;
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {1'b0, din, len[14:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_fifo(op, len[14:0], din);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_CAPACITY:  if (val != 0 && val <= STORE_BYTES) cap = val;
         CSR_SEG_LIMIT: if (val[10:0] <= SEGMENT_MAX) seg_lim = val[10:0];
         CSR_PACKET:    pkt_mode = val[0];
         CSR_TRIM:      trim_en = val[0];
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR t=%0t result %0d %s got %0d want %0d", $realtime, results_seen,
               what, got, want);
      mismatches++;
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      fifo_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) report_mismatch("unexpected transfer", 1, 0);
         else begin
            w = pending_results.pop_front();
            if (rsp_tuser !== w.status) report_mismatch("status", rsp_tuser, w.status);
            if (rsp_tdata[7:0] !== w.data_out)
               report_mismatch("data_out", rsp_tdata[7:0], w.data_out);
            if (rsp_tlast !== w.last) report_mismatch("last", rsp_tlast, w.last);
            if (rsp_tdata[23:8] !== w.free_bytes)
               report_mismatch("free_bytes", $signed(rsp_tdata[23:8]), $signed(w.free_bytes));
         end
      end
   end

   // one segment write, one read, a trim, or noise, built from the predicted state
   task automatic random_transfer();
      int unsigned n, k, pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(seg_lim + 2) : $urandom_range(1, 12);
         send_op(OP_WRITE_BEGIN, n);
         k = wr_left;
         if ($urandom_range(9) == 0 && k > 0) k = $urandom_range(k - 1);
         repeat (k) send_op(OP_WRITE_BYTE, 0, 8'($urandom));
      end else if (pick < 80) begin
         n = (stored > 0) ? $urandom_range((stored < 20) ? stored : 20) : 0;
         if ($urandom_range(9) == 0) n = stored + 1;
         send_op(OP_READ_BEGIN, n);
         k = rd_left;
         if ($urandom_range(4) == 0) k = k + 1;
         else if ($urandom_range(9) == 0 && k > 0) k = $urandom_range(k - 1);
         repeat (k) send_op(OP_READ_BYTE, 0);
      end else if (pick < 90) begin
         send_op(OP_TRIM, $urandom_range(32767));
      end else begin
         send_op(3'($urandom_range(7)), $urandom_range(32767), 8'($urandom));
      end
   endtask

   task automatic test_directed();
      write_reg(CSR_SEG_LIMIT, 15'd0);
      send_op(OP_WRITE_BEGIN, 0);
      send_op(OP_WRITE_BEGIN, 1);
      send_op(OP_WRITE_BYTE, 0, 8'hFF);
      send_op(OP_READ_BYTE, 0);
      send_op(OP_READ_BEGIN, 1);
      send_op(OP_READ_BEGIN, 0);
      send_op(3'd5, 15'h7FFF, 8'hFF);
      send_op(3'd6, 0);
      send_op(3'd7, 0);
      send_op(OP_TRIM, 0);
      settle();
      write_reg(CSR_SEG_LIMIT, 15'd1024);
      send_op(OP_WRITE_BEGIN, 1025);
      send_op(OP_WRITE_BEGIN, 8193 & 1023);
      send_op(OP_WRITE_BEGIN, 3);
      send_op(OP_WRITE_BYTE, 0, 8'h00);
      send_op(OP_WRITE_BEGIN, 2);           // abandons the partial segment
      send_op(OP_WRITE_BYTE, 0, 8'hA5);
      send_op(OP_WRITE_BYTE, 0, 8'h5A);
      send_op(OP_READ_BEGIN, 3);
      send_op(OP_READ_BEGIN, 2);            // opens the read; READ_BEGIN 3 exceeds the 2 stored bytes
      send_op(OP_READ_BYTE, 0);
      send_op(OP_READ_BYTE, 0);
      send_op(OP_READ_BYTE, 0);
      settle();
   endtask

   task automatic test_register_limits();
      write_reg(CSR_CAPACITY, 15'd0);
      write_reg(CSR_CAPACITY, 15'd16385);
      write_reg(CSR_CAPACITY, 15'h7FFF);
      write_reg(CSR_SEG_LIMIT, 15'd1025);
      write_reg(CSR_SEG_LIMIT, 15'h7FFF);
      write_reg(CSR_SEG_LIMIT, 15'h0805);   // upper bits masked off
      write_reg(CSR_PACKET, 15'h7FFE);
      write_reg(CSR_TRIM, 15'h7FFE);
      send_op(OP_WRITE_BEGIN, 6);
      send_op(OP_WRITE_BEGIN, 5);
      repeat (5) send_op(OP_WRITE_BYTE, 0, 8'($urandom));
      send_op(OP_READ_BEGIN, 5);
      repeat (5) send_op(OP_READ_BYTE, 0);
      settle();
   endtask

   task automatic test_trim_all();
      write_reg(CSR_CAPACITY, 15'd16384);
      write_reg(CSR_SEG_LIMIT, 15'd1024);
      repeat (4) begin
         send_op(OP_WRITE_BEGIN, 1);
         if (wr_left > 0) send_op(OP_WRITE_BYTE, 0, 8'($urandom));
      end
      settle();
      write_reg(CSR_CAPACITY, 15'd1);
      write_reg(CSR_TRIM, 15'd1);
      send_op(OP_TRIM, 0);
      send_op(OP_READ_BEGIN, 2);
      send_op(OP_READ_BEGIN, 1);
      send_op(OP_READ_BYTE, 0);
      settle();
   endtask

   task automatic test_trim_shrink();
      write_reg(CSR_CAPACITY, 15'd16384);
      write_reg(CSR_TRIM, 15'd0);
      write_reg(CSR_SEG_LIMIT, 15'd40);
      send_op(OP_WRITE_BEGIN, 40);
      repeat (40) send_op(OP_WRITE_BYTE, 0, 8'($urandom));
      send_op(OP_WRITE_BEGIN, 7);
      repeat (7) send_op(OP_WRITE_BYTE, 0, 8'($urandom));
      send_op(OP_WRITE_BEGIN, 3);           // left open across the trim
      send_op(OP_WRITE_BYTE, 0, 8'h11);
      send_op(OP_READ_BEGIN, 45);
      repeat (5) send_op(OP_READ_BYTE, 0);
      settle();
      write_reg(CSR_CAPACITY, 15'd1);
      send_op(OP_TRIM, 0);
      send_op(OP_WRITE_BEGIN, 1);
      settle();
      write_reg(CSR_TRIM, 15'd1);
      send_op(OP_TRIM, 0);
      send_op(OP_READ_BYTE, 0);             // read still open, queue empty
      send_op(OP_WRITE_BYTE, 0, 8'h22);
      settle();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_CAPACITY, 15'd8192);
      write_reg(CSR_SEG_LIMIT, 15'd512);
      write_reg(CSR_TRIM, 15'd0);
      hold_cycles = 300;
      repeat (12) random_transfer();
      settle();
   endtask

   task automatic test_random(input int idle, input int stall, input int unsigned capv,
                              input int unsigned limv, input bit pm, input bit te,
                              input int count);
      int target;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      write_reg(CSR_CAPACITY, 15'(capv));
      write_reg(CSR_SEG_LIMIT, 15'(limv));
      write_reg(CSR_PACKET, 15'(pm));
      write_reg(CSR_TRIM, 15'(te));
      target = items_sent + count;
      while (items_sent < target) random_transfer();
      settle();
   endtask

   initial begin
      cap = 8192; seg_lim = 512; pkt_mode = 0; trim_en = 0;
      rd_ptr = 0; wr_ptr = 0; seg_head = 0; seg_tail = 0; seg_cnt = 0;
      stored = 0; head_left = 0; wr_left = 0; rd_left = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_limits();
      test_trim_all();
      test_trim_shrink();
      test_backpressure();
      test_random(0, 0, 8192, 512, 0, 0, 60);
      test_random(62, 0, 64, 20, 1, 0, 60);
      test_random(0, 62, 16384, 1024, 0, 1, 60);
      test_random(8, 8, 30, 0, 1, 1, 30);
      test_random(8, 8, 40, 16, 1, 1, 60);
      test_random(62, 62, 1, 1, 0, 1, 50);
      $display("Run covered %0d operations and %0d results over six register settings,",
               items_sent, results_seen);
      $display("trims after capacity shrink, packet-mode drops and a long output stall.");
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d results outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
   end
endmodule
